@@ rtl/swts_pkg.sv @@
// Package with the word types and event codes of the slot wheel scheduler.
`timescale 1ns / 1ps
`default_nettype none
package swts_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] packet_tag;
      logic [7:0]  packet_len;
      logic        has_prefix;
      logic [2:0]  face_index;
      logic [1:0]  probe_index;
      logic [15:0] delay_ms;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [2:0]  store_index;
      logic [31:0] out_tag;
      logic [8:0]  out_len;
      logic [2:0]  out_face;
      logic [1:0]  out_probe;
   } rsp_word_type;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_SCHED = 2'd1;
   localparam logic [1:0] ACT_REPLY = 2'd2;

   localparam logic [3:0] EV_IDLE     = 4'd0;
   localparam logic [3:0] EV_SEND     = 4'd1;
   localparam logic [3:0] EV_DUE      = 4'd2;
   localparam logic [3:0] EV_DISABLED = 4'd3;
   localparam logic [3:0] EV_ENQUEUED = 4'd4;
   localparam logic [3:0] EV_DUP      = 4'd5;
   localparam logic [3:0] EV_FULL     = 4'd6;
   localparam logic [3:0] EV_NO_SLOT  = 4'd7;
   localparam logic [3:0] EV_RESCHED  = 4'd8;
   localparam logic [3:0] EV_LOST     = 4'd9;

   // Slot code: bit 6 marks a probe, otherwise entry+1 or zero for empty.
   localparam logic [6:0] PROBE_MARK = 7'h40;

endpackage
`default_nettype wire

@@ rtl/slot_wheel_tx_scheduler_unit.sv @@
// Top level of the slot wheel transmit scheduler and its sequencer.
//
// The req channel takes one word per action: a tick, a schedule request
// or a probe reply. The rsp channel returns exactly one word per request.
// The csr port writes the four probe enable bits at any edge with csr_we.
// One item is worked at a time by a sequencer around two memories.
// A tick reads the current wheel slot, clears it and then reads the store
// entry that it names. A schedule request scans the store entry by entry,
// then the wheel slot by slot; a probe reply walks the wheel from its start
// slot. Each entry or slot needs a read state and a compare state, since
// each memory has a single registered read port. After each result the
// block returns to idle, where the next word is taken.
// After reset the wheel is swept once, one slot a cycle, writing the
// four probe slots and clearing the rest; req_ready stays low meanwhile.
// The result waits in an output register; while rsp_ready is low the
// next word is still taken and worked up to its own result.
`timescale 1ns / 1ps
`default_nettype none
module slot_wheel_tx_scheduler_unit #(
   parameter int SLOTS_PER_SECOND = 4,
   parameter int WHEEL_SECONDS    = 16,
   parameter int STORE_ENTRIES    = 8,
   parameter int PREFIX_LEN       = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire swts_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output swts_pkg::rsp_word_type     rsp_word,
   input  wire logic                  csr_we,
   input  wire logic [3:0]            csr_wdata
);

   localparam int SLOTS = SLOTS_PER_SECOND * WHEEL_SECONDS;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW    = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
   localparam int SPAN  = WHEEL_SECONDS * 1000;
   localparam int CW    = SW + 1;
   localparam logic [SW-1:0] P1_SLOT = SW'(9 * SLOTS_PER_SECOND);
   localparam logic [SW-1:0] P2_SLOT = SW'(3 * SLOTS_PER_SECOND);
   localparam logic [SW-1:0] P3_SLOT = SW'(6 * SLOTS_PER_SECOND);
   localparam logic [SW-1:0] LAST    = SW'(SLOTS - 1);
   // Reciprocal of 1000 scaled by 2^32; exact for products below 2^22.
   localparam logic [22:0] RECIP_1000 = 23'd4294968;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_TICK_RD, ST_TICK_EV, ST_TICK_ST,
      ST_DUP_RD, ST_DUP_CMP, ST_DIV, ST_WH_RD, ST_WH_CMP, ST_OUT
   } state_type;

   state_type state_ff;
   logic [SW-1:0] cur_ff, slot_ff, sweep_ff;
   logic [CW-1:0] count_ff;
   logic [EW:0] scan_ff;
   logic [EW-1:0] free_ff;
   logic free_ok_ff, dup_ff, is_sched_ff;
   logic [3:0] en_ff;
   logic [1:0] probe_ff;
   logic [31:0] tag_ff;
   logic [8:0] len_ff;
   logic [2:0] face_ff;
   logic [6:0] code_ff;
   logic [31:0] prod_ff;
   logic rsp_valid_ff;
   swts_pkg::rsp_word_type rsp_ff, res_ff;

   // Memory ports.
   logic w_we;
   logic [SW-1:0] w_wa, w_ra;
   logic [6:0] w_wd, w_rd;
   logic s_we, s_set, s_clr;
   logic [EW-1:0] s_wa, s_va, s_ra;
   logic [43:0] s_rd;
   logic [STORE_ENTRIES-1:0] s_valid;

   swts_wheel #(.SLOTS(SLOTS), .SW(SW)) u_wheel (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd)
   );

   swts_store #(.ENTRIES(STORE_ENTRIES), .EW(EW)) u_store (
      .clock(clock), .reset(reset), .wr_en(s_we), .wr_addr(s_wa),
      .wr_data({tag_ff, len_ff, face_ff}), .set_valid(s_set),
      .clr_valid(s_clr), .valid_addr(s_va), .rd_addr(s_ra),
      .rd_data(s_rd), .valid(s_valid)
   );

   // Initial content of a wheel slot during the clearing pass.
   logic [6:0] init_code;
   always_comb begin
      init_code = 7'd0;
      if (sweep_ff == '0)    init_code = swts_pkg::PROBE_MARK | 7'd0;
      if (sweep_ff == P1_SLOT) init_code = swts_pkg::PROBE_MARK | 7'd1;
      if (sweep_ff == P2_SLOT) init_code = swts_pkg::PROBE_MARK | 7'd2;
      if (sweep_ff == P3_SLOT) init_code = swts_pkg::PROBE_MARK | 7'd3;
   end

   // Slot offset and count of a reply: the delay product and the rest of the span,
   // each divided by 1000 through a multiplication by the scaled reciprocal.
   logic [31:0] off_full, cnt_full;
   logic [22:0] rem_span;
   logic [45:0] off_prod, cnt_prod;
   always_comb begin
      rem_span = 23'(32'(SPAN) * 32'(SLOTS_PER_SECOND) - prod_ff);
      off_prod = 46'(prod_ff[22:0]) * 46'(RECIP_1000);
      cnt_prod = 46'(rem_span) * 46'(RECIP_1000);
      off_full = 32'(off_prod[45:32]);
      cnt_full = 32'(cnt_prod[45:32]);
   end

   logic [SW:0] slot_sum;
   assign slot_sum = {1'b0, cur_ff} + {1'b0, off_full[SW-1:0] };
   logic [SW-1:0] slot_next;
   assign slot_next = (slot_ff == LAST) ? '0 : slot_ff + 1'b1;

   logic [EW-1:0] scan_idx;
   assign scan_idx = scan_ff[EW-1:0];
   logic [EW-1:0] tick_e;
   assign tick_e = EW'(code_ff[5:0] - 6'd1);
   // Store entry named by the slot code just read from the wheel.
   logic [EW-1:0] rd_e;
   assign rd_e = EW'(w_rd[5:0] - 6'd1);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Memory control from the sequencer state.
   always_comb begin
      w_we = 1'b0; w_wa = slot_ff; w_wd = 7'd0; w_ra = slot_ff;
      s_we = 1'b0; s_set = 1'b0; s_clr = 1'b0;
      s_wa = free_ff; s_va = free_ff; s_ra = scan_idx;
      unique case (state_ff)
         ST_CLEAR: begin
            w_we = 1'b1; w_wa = sweep_ff; w_wd = init_code;
         end
         ST_TICK_RD: w_ra = cur_ff;
         ST_TICK_EV: begin
            w_we = 1'b1; w_wa = cur_ff; w_wd = 7'd0;
            s_ra = rd_e;
         end
         ST_TICK_ST: begin
            if (res_ff.event_res == swts_pkg::EV_SEND) begin
               s_clr = 1'b1; s_va = tick_e;
            end
         end
         ST_WH_CMP: begin
            if (w_rd == 7'd0) begin
               w_we = 1'b1; w_wa = slot_ff;
               if (is_sched_ff) begin
                  w_wd = 7'(free_ff) + 7'd1;
                  s_we = 1'b1; s_set = 1'b1;
               end else begin
                  w_wd = swts_pkg::PROBE_MARK | 7'(probe_ff);
               end
            end
         end
         default: ;
      endcase
   end

   // Sequencer, enable register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         cur_ff <= '0;
         en_ff <= 4'hF;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) en_ff <= csr_wdata;
         // The result word is held until taken; a new one loads when free.
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  res_ff <= '0;
                  tag_ff <= req_word.packet_tag;
                  len_ff <= {1'b0, req_word.packet_len} +
                            (req_word.has_prefix ? 9'(PREFIX_LEN) : 9'd0);
                  face_ff <= req_word.face_index;
                  probe_ff <= req_word.probe_index;
                  prod_ff <= 32'(req_word.delay_ms) * 32'(SLOTS_PER_SECOND);
                  scan_ff <= '0;
                  free_ok_ff <= 1'b0;
                  dup_ff <= 1'b0;
                  case (req_word.action)
                     swts_pkg::ACT_TICK: state_ff <= ST_TICK_RD;
                     swts_pkg::ACT_SCHED: begin
                        is_sched_ff <= 1'b1;
                        state_ff <= ST_DUP_RD;
                     end
                     swts_pkg::ACT_REPLY: begin
                        is_sched_ff <= 1'b0;
                        state_ff <= ST_DIV;
                     end
                     default: state_ff <= ST_OUT;
                  endcase
               end
            end
            ST_TICK_RD: state_ff <= ST_TICK_EV;
            ST_TICK_EV: begin
               code_ff <= w_rd;
               cur_ff <= (cur_ff == LAST) ? '0 : cur_ff + 1'b1;
               if (w_rd[6]) begin
                  res_ff.out_probe <= w_rd[1:0];
                  res_ff.event_res <= en_ff[w_rd[1:0]] ? swts_pkg::EV_DUE
                                                       : swts_pkg::EV_DISABLED;
               end else if (w_rd != 7'd0 && 32'(w_rd) <= 32'(STORE_ENTRIES)) begin
                  res_ff.event_res <= swts_pkg::EV_SEND;
               end
               state_ff <= ST_TICK_ST;
            end
            ST_TICK_ST: begin
               if (res_ff.event_res == swts_pkg::EV_SEND) begin
                  res_ff.store_index <= 3'(tick_e);
                  res_ff.out_tag <= s_rd[43:12];
                  res_ff.out_len <= s_rd[11:3];
                  res_ff.out_face <= s_rd[2:0];
               end
               state_ff <= ST_OUT;
            end
            ST_DUP_RD: begin
               if (scan_ff == (EW+1)'(STORE_ENTRIES)) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_DUP_CMP;
               end
            end
            ST_DUP_CMP: begin
               if (!s_valid[scan_idx]) begin
                  free_ff <= scan_idx; free_ok_ff <= 1'b1;
               end else if (s_rd[43:12] == tag_ff && s_rd[11:3] == len_ff) begin
                  dup_ff <= 1'b1;
               end
               scan_ff <= scan_ff + 1'b1;
               state_ff <= ST_DUP_RD;
            end
            ST_DIV: begin
               if (is_sched_ff) begin
                  // A packet searches the whole wheel from the current slot.
                  slot_ff <= cur_ff;
                  count_ff <= CW'(SLOTS);
                  if (dup_ff) begin
                     res_ff.event_res <= swts_pkg::EV_DUP; state_ff <= ST_OUT;
                  end else if (!free_ok_ff) begin
                     res_ff.event_res <= swts_pkg::EV_FULL; state_ff <= ST_OUT;
                  end else state_ff <= ST_WH_RD;
               end else begin
                  slot_ff <= (slot_sum >= (SW+1)'(SLOTS)) ?
                             SW'(slot_sum - (SW+1)'(SLOTS)) : slot_sum[SW-1:0];
                  res_ff.out_probe <= probe_ff;
                  count_ff <= CW'(cnt_full);
                  if (prod_ff >= 32'(SPAN) * 32'(SLOTS_PER_SECOND) || cnt_full == 0)
                  begin
                     res_ff.event_res <= swts_pkg::EV_LOST; state_ff <= ST_OUT;
                  end else state_ff <= ST_WH_RD;
               end
            end
            ST_WH_RD: begin
               if (count_ff == '0) begin
                  res_ff.event_res <= is_sched_ff ? swts_pkg::EV_NO_SLOT
                                                  : swts_pkg::EV_LOST;
                  state_ff <= ST_OUT;
               end else state_ff <= ST_WH_CMP;
            end
            ST_WH_CMP: begin
               if (w_rd == 7'd0) begin
                  if (is_sched_ff) begin
                     res_ff.event_res <= swts_pkg::EV_ENQUEUED;
                     res_ff.store_index <= 3'(free_ff);
                  end else res_ff.event_res <= swts_pkg::EV_RESCHED;
                  state_ff <= ST_OUT;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  slot_ff <= slot_next;
                  state_ff <= ST_WH_RD;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_ff <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/swts_store.sv @@
// Packet store memory with its per-entry valid flags.
`timescale 1ns / 1ps
`default_nettype none
module swts_store #(
   parameter int ENTRIES = 8,
   parameter int EW      = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [EW-1:0] wr_addr,
   input  wire logic [43:0]   wr_data,
   input  wire logic          set_valid,
   input  wire logic          clr_valid,
   input  wire logic [EW-1:0] valid_addr,
   input  wire logic [EW-1:0] rd_addr,
   output logic [43:0]        rd_data,
   output logic [ENTRIES-1:0] valid
);

   // Tag, length and face of each entry; read data is registered.
   logic [43:0] mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

   // Valid flags clear at reset; a store fill sets, a send clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (set_valid) begin
         valid_ff[valid_addr] <= 1'b1;
      end else if (clr_valid) begin
         valid_ff[valid_addr] <= 1'b0;
      end
   end

   assign valid = valid_ff;

endmodule
`default_nettype wire

@@ rtl/swts_wheel.sv @@
// Slot wheel memory, cleared by the sequencer of the top level after reset.
`timescale 1ns / 1ps
`default_nettype none
module swts_wheel #(
   parameter int SLOTS = 64,
   parameter int SW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [SW-1:0] wr_addr,
   input  wire logic [6:0]    wr_data,
   input  wire logic [SW-1:0] rd_addr,
   output logic [6:0]         rd_data
);

   logic [6:0] mem [SLOTS];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ verif/slot_wheel_tx_scheduler_unit_tb.sv @@
// Self-checking testbench of the slot wheel transmit scheduler, with its own prediction.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: the predicted scheduler state and the queue of expected result words.
class wheel_scoreboard;
   localparam int WHEEL = 64;
   localparam int ENTRIES = 8;
   localparam int SPS = 4;
   localparam int SPAN_MS = 16000;
   localparam int PREFIX = 7;

   logic [6:0]  wheel_code [WHEEL];
   int unsigned cur_slot;
   logic [3:0]  enables;
   bit          used [ENTRIES];
   logic [31:0] ent_tag [ENTRIES];
   logic [8:0]  ent_len [ENTRIES];
   logic [2:0]  ent_face [ENTRIES];
   swts_pkg::rsp_word_type pending [$];
   int errors;
   int sends;
   int enqueues;
   int probe_events;

   function new();
      for (int i = 0; i < WHEEL; i++) wheel_code[i] = '0;
      wheel_code[0] = swts_pkg::PROBE_MARK | 7'd0;
      wheel_code[9 * SPS] = swts_pkg::PROBE_MARK | 7'd1;
      wheel_code[3 * SPS] = swts_pkg::PROBE_MARK | 7'd2;
      wheel_code[6 * SPS] = swts_pkg::PROBE_MARK | 7'd3;
      cur_slot = 0;
      enables = 4'hf;
      for (int i = 0; i < ENTRIES; i++) begin
         used[i] = 0;
         ent_tag[i] = '0;
         ent_len[i] = '0;
         ent_face[i] = '0;
      end
      errors = 0;
      sends = 0;
      enqueues = 0;
      probe_events = 0;
   endfunction

   // First empty slot of the window that a delay opens, or -1.
   function int free_slot(int unsigned delay);
      int unsigned count;
      int unsigned pos;
      if (delay >= SPAN_MS) return -1;
      count = (SPAN_MS - delay) * SPS / 1000;
      pos = cur_slot + delay * SPS / 1000;
      for (int unsigned i = 0; i < count; i++)
         if (wheel_code[(pos + i) % WHEEL] == 0) return (pos + i) % WHEEL;
      return -1;
   endfunction

   // Works out the result of one accepted request word and queues it.
   function void note_request(swts_pkg::req_word_type w);
      swts_pkg::rsp_word_type r;
      logic [6:0] code;
      logic [8:0] total;
      int free_idx;
      int s;
      bit dup;
      r = '0;
      if (w.action == swts_pkg::ACT_TICK) begin
         code = wheel_code[cur_slot];
         wheel_code[cur_slot] = '0;
         cur_slot = (cur_slot + 1) % WHEEL;
         if (code[6]) begin
            r.out_probe = code[1:0];
            r.event_res = enables[code[1:0]] ? swts_pkg::EV_DUE : swts_pkg::EV_DISABLED;
            probe_events++;
         end else if (code != 0 && code <= ENTRIES) begin
            r.event_res = swts_pkg::EV_SEND;
            r.store_index = 3'(code - 7'd1);
            r.out_tag = ent_tag[code - 1];
            r.out_len = ent_len[code - 1];
            r.out_face = ent_face[code - 1];
            used[code - 1] = 0;
            sends++;
         end
      end else if (w.action == swts_pkg::ACT_SCHED) begin
         total = 9'(w.packet_len + (w.has_prefix ? PREFIX : 0));
         free_idx = -1;
         dup = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!used[i]) free_idx = i;
            else if (ent_len[i] == total && ent_tag[i] == w.packet_tag) dup = 1;
         end
         if (dup) r.event_res = swts_pkg::EV_DUP;
         else if (free_idx < 0) r.event_res = swts_pkg::EV_FULL;
         else begin
            s = free_slot(0);
            if (s < 0) r.event_res = swts_pkg::EV_NO_SLOT;
            else begin
               used[free_idx] = 1;
               ent_tag[free_idx] = w.packet_tag;
               ent_len[free_idx] = total;
               ent_face[free_idx] = w.face_index;
               wheel_code[s] = 7'(free_idx + 1);
               r.event_res = swts_pkg::EV_ENQUEUED;
               r.store_index = 3'(free_idx);
               enqueues++;
            end
         end
      end else if (w.action == swts_pkg::ACT_REPLY) begin
         s = free_slot(w.delay_ms);
         r.out_probe = w.probe_index;
         if (s < 0) r.event_res = swts_pkg::EV_LOST;
         else begin
            wheel_code[s] = swts_pkg::PROBE_MARK | 7'(w.probe_index);
            r.event_res = swts_pkg::EV_RESCHED;
         end
      end
      pending.push_back(r);
   endfunction

   // Compares one accepted result word with the oldest expectation.
   function void check_result(swts_pkg::rsp_word_type got);
      swts_pkg::rsp_word_type exp_w;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, got);
         errors++;
         return;
      end
      exp_w = pending.pop_front();
      if (got.event_res !== exp_w.event_res) begin
         $display("%0t: event_res expected %0d got %0d", $time, exp_w.event_res, got.event_res);
         errors++;
      end
      if (got.store_index !== exp_w.store_index) begin
         $display("%0t: store_index expected %0d got %0d", $time, exp_w.store_index,
                  got.store_index);
         errors++;
      end
      if (got.out_tag !== exp_w.out_tag) begin
         $display("%0t: out_tag expected %h got %h", $time, exp_w.out_tag, got.out_tag);
         errors++;
      end
      if (got.out_len !== exp_w.out_len) begin
         $display("%0t: out_len expected %0d got %0d", $time, exp_w.out_len, got.out_len);
         errors++;
      end
      if (got.out_face !== exp_w.out_face) begin
         $display("%0t: out_face expected %0d got %0d", $time, exp_w.out_face, got.out_face);
         errors++;
      end
      if (got.out_probe !== exp_w.out_probe) begin
         $display("%0t: out_probe expected %0d got %0d", $time, exp_w.out_probe,
                  got.out_probe);
         errors++;
      end
   endfunction
endclass

module slot_wheel_tx_scheduler_unit_tb;

   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   swts_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   swts_pkg::rsp_word_type rsp_word;
   logic csr_we = 0;
   logic [3:0] csr_wdata = '0;
   int cycles = 0;
   int sent_words = 0;
   bit idle_receiver = 0;
   logic [31:0] recent_tags [4];
   wheel_scoreboard board;

   slot_wheel_tx_scheduler_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Cycle counter with the timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check accepted words, stall at random.
   initial begin
      int gap;
      board = new();
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_result(rsp_word);
         if (rsp_valid && rsp_ready || !rsp_ready) begin
            gap = idle_receiver ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap == 0) rsp_ready <= 1;
            else begin
               rsp_ready <= 0;
               repeat (gap) @(posedge clock);
               rsp_ready <= 1;
            end
         end
      end
   end

   // Sends one word after a random gap, or none with no_gap, and waits for its acceptance.
   // Valid stays high after acceptance only until the caller moves on.
   task automatic send_word(swts_pkg::req_word_type w, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      board.note_request(w);
      sent_words++;
   endtask

   // Waits for every expected word, then a margin for the block to settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_enables(logic [3:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.enables = v;
   endtask

   function automatic swts_pkg::req_word_type make_word(logic [1:0] act);
      swts_pkg::req_word_type w;
      w = {$urandom, $urandom};
      w.action = act;
      if ($urandom_range(0, 1)) w.packet_tag = recent_tags[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) w.delay_ms = 16'($urandom_range(0, 17000));
      return w;
   endfunction

   initial begin
      swts_pkg::req_word_type w;
      int pick;
      for (int i = 0; i < 4; i++) recent_tags[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed words: extremes, every action, duplicates, full store, unused action.
      w = '0; w.action = swts_pkg::ACT_TICK; send_word(w, 0);
      w = '1; w.action = swts_pkg::ACT_SCHED; send_word(w, 0);
      send_word(w, 0);
      w.has_prefix = 0; send_word(w, 0);
      w = '0; w.action = swts_pkg::ACT_SCHED; send_word(w, 1);
      for (int i = 0; i < 5; i++) begin
         w = make_word(swts_pkg::ACT_SCHED); w.packet_tag = i; send_word(w, 1);
      end
      w.packet_tag = 32'h5a5a; send_word(w, 0);
      w = '0; w.action = swts_pkg::ACT_REPLY; w.delay_ms = 16'hffff; w.probe_index = 2'd3;
      send_word(w, 0);
      w.delay_ms = 16'd15999; w.probe_index = 2'd1; send_word(w, 0);
      w.delay_ms = 16'd16000; send_word(w, 0);
      w.delay_ms = 16'd0; w.probe_index = 2'd0; send_word(w, 0);
      w = '1; send_word(w, 0);
      for (int i = 0; i < 8; i++) begin
         w = '0; w.action = swts_pkg::ACT_TICK; send_word(w, 0);
      end

      // Random phases with different enable settings, the block idle for each write.
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: write_enables(4'h0);
            1: write_enables(4'hf);
            2: write_enables(4'h5);
            3: write_enables(4'ha);
            default: write_enables(4'($urandom_range(0, 15)));
         endcase
         idle_receiver = (phase == 2);
         for (int i = 0; i < 100; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) w = make_word(swts_pkg::ACT_TICK);
            else if (pick < 15) w = make_word(swts_pkg::ACT_SCHED);
            else if (pick < 19) w = make_word(swts_pkg::ACT_REPLY);
            else w = make_word(2'd3);
            if ($urandom_range(0, 7) == 0) recent_tags[$urandom_range(0, 3)] = w.packet_tag;
            send_word(w, phase == 3);
            if (i == 50) begin
               req_valid <= 0;
               while (board.pending.size() != 0) @(posedge clock);
            end
         end
      end
      drain();
      $display("Sent %0d words: %0d packets enqueued, %0d sent, %0d probe slots reached.",
               sent_words, board.enqueues, board.sends, board.probe_events);
      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
